// ===== sv/pwtbl_pkg.sv =====
// Package for the per-worker token bucket limiter.
// Sizes, refill constants and register codes; no dependencies.
`default_nettype none
package pwtbl_pkg;

	localparam int WORKER_COUNT = 16;
	localparam int WIDX         = (WORKER_COUNT > 1) ? $clog2(WORKER_COUNT) : 1;

	localparam int IDX_W   = 6;
	localparam int TIME_W  = 48;
	localparam int LIM_W   = 16;
	localparam int DROP_W  = 32;

	// elapsed >= 1 s always saturates the bucket; below that 20 bits suffice
	localparam int ELAP_W  = 20;
	localparam int PROD_W  = ELAP_W + LIM_W;
	localparam logic [TIME_W-1:0] US_PER_SEC = TIME_W'(1000000);

	// floor(p / 1e6) = floor((p >> 6) / 15625), done as (x * M) >> 45, exact for x < 2^30
	localparam int DIV_SHIFT_LO = 6;
	localparam int RECIP_X_W    = PROD_W - DIV_SHIFT_LO;
	localparam int RECIP_W      = 32;
	localparam logic [RECIP_W-1:0] RECIP_M = 32'd2251799814;
	localparam int RECIP_SHIFT  = 45;
	localparam int RECIP_P_W    = RECIP_X_W + RECIP_W;

	localparam logic [LIM_W-1:0] RATE_LIMIT_RESET = 16'd20;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [0:0] REG_RATE_LIMIT = 1'b0;

	typedef logic [IDX_W-1:0]  worker_idx_t;
	typedef logic [TIME_W-1:0] time_us_t;
	typedef logic [LIM_W-1:0]  tokens_t;
	typedef logic [DROP_W-1:0] drops_t;

endpackage
`default_nettype wire

// ===== sv/pwtbl_ifs.sv =====
// Valid/ready channel interfaces for limiter requests and results.
// Depends on pwtbl_pkg.
`default_nettype none
interface pwtbl_req_if;
	import pwtbl_pkg::*;
	logic        valid;
	logic        ready;
	worker_idx_t worker_index;
	time_us_t    time_now_us;

	modport source (output valid, output worker_index, output time_now_us, input ready);
	modport sink   (input valid, input worker_index, input time_now_us, output ready);
endinterface

interface pwtbl_rsp_if;
	import pwtbl_pkg::*;
	logic    valid;
	logic    ready;
	logic    allowed;
	tokens_t tokens_left;
	drops_t  drops_total;

	modport source (output valid, output allowed, output tokens_left, output drops_total,
		input ready);
	modport sink   (input valid, input allowed, input tokens_left, input drops_total,
		output ready);
endinterface
`default_nettype wire

// ===== sv/per_worker_token_bucket_limiter.sv =====
// Per-worker token bucket limiter: allow/drop decision per request beat.
// The result is registered through stages 1 to 4 and the result register after the request beat is taken.
// Throughput: one beat per cycle; the whole pipeline stalls only on result backpressure.
// Refill time is read/written in stage 1, buckets and drop count in stage 4, so no forwarding.
// Reset: buckets, refill times and drop counter clear; rate_limit returns to 20.
// Depends on pwtbl_pkg and pwtbl_ifs.
`default_nettype none
module per_worker_token_bucket_limiter (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            psel,
	input  wire                            penable,
	input  wire                            pwrite,
	input  wire [pwtbl_pkg::PADDR_W-1:0]   paddr,
	input  wire [pwtbl_pkg::PDATA_W-1:0]   pwdata,
	output logic [pwtbl_pkg::PDATA_W-1:0]  prdata,
	output logic                           pready,
	pwtbl_req_if.sink                      req,
	pwtbl_rsp_if.source                    rsp
);
	import pwtbl_pkg::*;

	typedef struct packed {
		logic            v;
		logic [WIDX-1:0] wi;
		logic            inr;
		logic            first;
		logic            pos;
		logic            big;
	} ctl_t;

	// config
	tokens_t rate_limit_q;
	logic    cfg_sel;

	assign pready  = 1'b1;
	assign cfg_sel = (paddr[PADDR_W-1:2] == REG_RATE_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_limit_q <= RATE_LIMIT_RESET;
		end else if (psel && penable && pwrite && cfg_sel) begin
			rate_limit_q <= pwdata[LIM_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (cfg_sel) begin
			prdata = PDATA_W'(rate_limit_q);
		end
	end

	// pipeline advance
	logic adv;
	logic out_valid_q;

	assign adv       = !out_valid_q || rsp.ready;
	assign req.ready = adv;

	// stage 1: input register, refill time read-modify-write
	logic            v_s1;
	worker_idx_t     idx_s1;
	time_us_t        now_s1;
	time_us_t        last_time_q [WORKER_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && req.valid) begin
			idx_s1 <= req.worker_index;
			now_s1 <= req.time_now_us;
		end
	end

	logic [WIDX-1:0] wi1;
	logic            inr1;
	time_us_t        last1;
	time_us_t        elapsed1;
	logic            pos1;

	assign inr1     = ({1'b0, idx_s1} < (IDX_W+1)'(WORKER_COUNT));
	assign wi1      = idx_s1[WIDX-1:0];
	assign last1    = last_time_q[wi1];
	assign elapsed1 = now_s1 - last1;
	assign pos1     = (now_s1 > last1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WORKER_COUNT; i++) begin
				last_time_q[i] <= '0;
			end
		end else if (adv && v_s1 && inr1 && (rate_limit_q != '0) && pos1) begin
			last_time_q[wi1] <= now_s1;
		end
	end

	// stage 2: elapsed time, flags
	ctl_t              c_s2;
	logic [ELAP_W-1:0] elap_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_s2    <= '0;
			elap_s2 <= '0;
		end else if (adv) begin
			c_s2.v     <= v_s1;
			c_s2.wi    <= wi1;
			c_s2.inr   <= inr1;
			c_s2.first <= (last1 == '0);
			c_s2.pos   <= pos1;
			c_s2.big   <= (elapsed1 >= US_PER_SEC);
			elap_s2    <= elapsed1[ELAP_W-1:0];
		end
	end

	// stage 3: elapsed * limit
	ctl_t              c_s3;
	logic [PROD_W-1:0] prod_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_s3    <= '0;
			prod_s3 <= '0;
		end else if (adv) begin
			c_s3    <= c_s2;
			prod_s3 <= PROD_W'(elap_s2) * PROD_W'(rate_limit_q);
		end
	end

	// stage 4: divide by 1e6 via reciprocal
	ctl_t                 c_s4;
	tokens_t              add_s4;
	logic [RECIP_P_W-1:0] recip_p;

	assign recip_p = RECIP_P_W'(prod_s3[PROD_W-1:DIV_SHIFT_LO]) * RECIP_P_W'(RECIP_M);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_s4   <= '0;
			add_s4 <= '0;
		end else if (adv) begin
			c_s4   <= c_s3;
			add_s4 <= recip_p[RECIP_SHIFT+LIM_W-1:RECIP_SHIFT];
		end
	end

	// stage 4 decision: bucket read-modify-write, drop counter
	tokens_t        bucket_q [WORKER_COUNT];
	drops_t         drop_q;
	tokens_t        stored4;
	tokens_t        base4;
	logic [LIM_W:0] sum4;
	tokens_t        tok4;
	tokens_t        tl4;
	logic           allow4;
	logic           upd4;

	assign stored4 = bucket_q[c_s4.wi];

	always_comb begin
		allow4 = 1'b1;
		tl4    = '0;
		upd4   = 1'b0;
		base4  = c_s4.first ? rate_limit_q : stored4;
		sum4   = {1'b0, base4} + {1'b0, add_s4};
		tok4   = base4;
		if (!c_s4.inr) begin
			tl4 = '0;
		end else if (rate_limit_q == '0) begin
			tl4 = stored4;
		end else begin
			upd4 = 1'b1;
			if (!c_s4.first && c_s4.pos) begin
				if (c_s4.big || (sum4 > {1'b0, rate_limit_q})) begin
					tok4 = rate_limit_q;
				end else begin
					tok4 = sum4[LIM_W-1:0];
				end
			end
			if (tok4 != '0) begin
				tok4 = tok4 - 1'b1;
			end else begin
				allow4 = 1'b0;
			end
			tl4 = tok4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WORKER_COUNT; i++) begin
				bucket_q[i] <= '0;
			end
			drop_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= c_s4.v;
			if (c_s4.v && upd4) begin
				bucket_q[c_s4.wi] <= tok4;
			end
			if (c_s4.v && !allow4) begin
				drop_q <= drop_q + 1'b1;
			end
		end
	end

	// result register
	logic    allowed_q;
	tokens_t tokens_left_q;
	drops_t  drops_total_q;

	always_ff @(posedge clk) begin
		if (adv && c_s4.v) begin
			allowed_q     <= allow4;
			tokens_left_q <= tl4;
			drops_total_q <= allow4 ? drop_q : drop_q + 1'b1;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.allowed     = allowed_q;
	assign rsp.tokens_left = tokens_left_q;
	assign rsp.drops_total = drops_total_q;

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for per_worker_token_bucket_limiter: directed and random request
// beats, with an in-bench bucket predictor checked against every result beat.
// Depends on pwtbl_pkg, pwtbl_ifs and the limiter RTL.
`default_nettype none
module tb;
	import pwtbl_pkg::*;

	localparam int IDLE_PCT       = 18;
	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_BEATS    = 135;
	localparam logic [PADDR_W-1:0] RATE_LIMIT_ADDR = PADDR_W'(4 * REG_RATE_LIMIT);

	typedef struct packed {
		logic    allowed;
		tokens_t tokens_left;
		drops_t  drops_total;
	} verdict_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	pwtbl_req_if req_ch();
	pwtbl_rsp_if rsp_ch();

	per_worker_token_bucket_limiter u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_ch),
		.rsp     (rsp_ch)
	);

	// predictor state
	tokens_t     bucket_level [WORKER_COUNT];
	time_us_t    last_refill  [WORKER_COUNT];
	drops_t      drop_count   = '0;
	tokens_t     limit_shadow = RATE_LIMIT_RESET;
	verdict_t    pending_verdicts[$];

	time_us_t    clock_us    = 48'd4000000;
	worker_idx_t last_worker = '0;
	bit          idle_on     = 1'b1;
	int          fail_count  = 0;
	int          quiet_cycles = 0;

	always #5 clk = ~clk;

	function automatic verdict_t predict_verdict(input worker_idx_t w, input time_us_t now);
		verdict_t    v;
		logic [63:0] level;
		logic [63:0] gain;
		v.allowed     = 1'b1;
		v.tokens_left = '0;
		v.drops_total = drop_count;
		if (w >= WORKER_COUNT)
			return v;
		if (limit_shadow == '0) begin
			v.tokens_left = bucket_level[w];
			return v;
		end
		if (last_refill[w] == '0) begin
			last_refill[w]  = now;
			bucket_level[w] = limit_shadow;
		end
		level = 64'(bucket_level[w]);
		if (now > last_refill[w]) begin
			gain = (64'(now - last_refill[w]) * 64'(limit_shadow)) / 64'(US_PER_SEC);
			level = level + gain;
			if (level > 64'(limit_shadow))
				level = 64'(limit_shadow);
			last_refill[w] = now;
		end
		if (level != 0) begin
			level = level - 1;
		end else begin
			v.allowed  = 1'b0;
			drop_count = drop_count + 1'b1;
		end
		bucket_level[w] = tokens_t'(level);
		v.tokens_left   = tokens_t'(level);
		v.drops_total   = drop_count;
		return v;
	endfunction

	// result beat checker
	always @(posedge clk) begin
		verdict_t exp_v;
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (pending_verdicts.size() == 0) begin
				$error("result beat with no request outstanding");
				fail_count++;
			end else begin
				exp_v = pending_verdicts.pop_front();
				if (rsp_ch.allowed !== exp_v.allowed) begin
					$error("allowed: expected %0d, got %0d", exp_v.allowed, rsp_ch.allowed);
					fail_count++;
				end
				if (rsp_ch.tokens_left !== exp_v.tokens_left) begin
					$error("tokens_left: expected %0d, got %0d", exp_v.tokens_left,
						rsp_ch.tokens_left);
					fail_count++;
				end
				if (rsp_ch.drops_total !== exp_v.drops_total) begin
					$error("drops_total: expected %0d, got %0d", exp_v.drops_total,
						rsp_ch.drops_total);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	always @(negedge clk) begin
		rsp_ch.ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
	end

	task automatic send_request(input worker_idx_t w, input time_us_t t);
		while (idle_on && $urandom_range(99) < IDLE_PCT) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.worker_index <= w;
		req_ch.time_now_us  <= t;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		pending_verdicts.push_back(predict_verdict(w, t));
		@(negedge clk);
	endtask

	task automatic wait_for_idle();
		req_ch.valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic check_rate_limit_reg(input tokens_t value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= RATE_LIMIT_ADDR;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== PDATA_W'(value)) begin
			$error("rate_limit: expected %0d, got %0d", value, prdata);
			fail_count++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic write_rate_limit(input tokens_t value);
		wait_for_idle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= RATE_LIMIT_ADDR;
		pwdata  <= PDATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		limit_shadow = value;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		check_rate_limit_reg(value);
	endtask

	task automatic test_register_reset();
		check_rate_limit_reg(RATE_LIMIT_RESET);
	endtask

	task automatic test_directed_cases();
		// reset limit: time zero refills twice, out-of-range workers, extreme times
		send_request(6'd0, 48'd0);
		send_request(6'd0, 48'd0);
		send_request(6'd63, 48'hFFFF_FFFF_FFFF);
		send_request(6'd16, time_us_t'({$urandom, $urandom}));
		send_request(6'd15, 48'd1);
		send_request(6'd15, 48'hFFFF_FFFF_FFFF);
		send_request(6'd15, 48'd1000);
		// limit 1: drops, time advances with no whole token, then refills of one token
		write_rate_limit(16'd1);
		send_request(6'd3, 48'd100);
		send_request(6'd3, 48'd100);
		send_request(6'd3, 48'd1000099);
		send_request(6'd3, 48'd2000099);
		send_request(6'd3, 48'd3000099);
		write_rate_limit(16'hFFFF);
		send_request(6'd4, 48'd7);
		send_request(6'd4, 48'd8);
		send_request(6'd4, 48'd24);
		// limiting off: state untouched
		write_rate_limit(16'd0);
		send_request(6'd4, 48'd100);
		send_request(6'd5, 48'd100);
		send_request(6'd40, 48'd100);
		// lowered limit: cap only on positive elapsed time
		write_rate_limit(16'd5);
		send_request(6'd4, 48'd24);
		send_request(6'd4, 48'd25);
		send_request(6'd5, 48'd0);
	endtask

	task automatic test_random_traffic(input tokens_t lim, input int beats);
		int          r;
		int          lim_eff;
		int          dmax;
		int          back;
		worker_idx_t w;
		time_us_t    t;
		write_rate_limit(lim);
		lim_eff = (lim == '0) ? 20 : int'(lim);
		dmax    = 1000000 / (16 * lim_eff);
		for (int i = 0; i < beats; i++) begin
			r = $urandom_range(99);
			w = worker_idx_t'($urandom_range(WORKER_COUNT - 1));
			t = clock_us;
			if (r < 75) begin
				clock_us = clock_us + time_us_t'($urandom_range(dmax));
				t = clock_us;
			end else if (r < 83) begin
				w = last_worker;
			end else if (r < 89) begin
				back = $urandom_range(50000);
				t = (r == 88 || clock_us <= time_us_t'(back)) ? '0 : clock_us - time_us_t'(back);
			end else if (r < 95) begin
				w = worker_idx_t'($urandom_range(63, WORKER_COUNT));
			end else begin
				clock_us = clock_us + time_us_t'($urandom_range(3000000));
				t = clock_us;
			end
			send_request(w, t);
			last_worker = w;
		end
	endtask

	task automatic test_back_to_back(input tokens_t lim);
		idle_on = 1'b0;
		test_random_traffic(lim, PHASE_BEATS);
		idle_on = 1'b1;
	endtask

	task automatic test_timestamp_jump(input tokens_t lim);
		clock_us = clock_us + time_us_t'({15'($urandom), 32'($urandom)});
		test_random_traffic(lim, PHASE_BEATS);
	endtask

	initial begin
		for (int i = 0; i < WORKER_COUNT; i++) begin
			bucket_level[i] = '0;
			last_refill[i]  = '0;
		end
		arst_n              = 1'b0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		req_ch.valid        = 1'b0;
		req_ch.worker_index = '0;
		req_ch.time_now_us  = '0;
		rsp_ch.ready        = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_register_reset();
		test_directed_cases();
		test_random_traffic(16'd1, PHASE_BEATS);
		test_random_traffic(16'd20, PHASE_BEATS);
		test_random_traffic(16'hFFFF, PHASE_BEATS);
		test_random_traffic(16'd0, PHASE_BEATS);
		test_back_to_back(16'd1000);
		test_timestamp_jump(tokens_t'($urandom_range(65535, 1)));
		test_random_traffic(16'd3, PHASE_BEATS);
		test_random_traffic(16'd2, PHASE_BEATS);

		wait_for_idle();
		if (fail_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
`default_nettype wire

// ===== files.f =====
sv/pwtbl_pkg.sv
sv/pwtbl_ifs.sv
sv/per_worker_token_bucket_limiter.sv
bench/tb.sv
